### hdl/netpbm_gray_pixmap_stream_decoder_macros.svh
// Assertion helpers for the netpbm stream decoder.
// Both helpers sample on i_clk and are held off while i_rst_n is low.
`ifndef NETPBM_GRAY_PIXMAP_STREAM_DECODER_MACROS_SVH
`define NETPBM_GRAY_PIXMAP_STREAM_DECODER_MACROS_SVH
`ifndef SYNTHESIS
// Whenever ante holds, cons must hold in the same cycle.
`define NGPD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("decoder check failed: implication");
// cond must never hold.
`define NGPD_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error("decoder check failed: forbidden condition");
`else
`define NGPD_ASSERT_IMP(lbl, ante, cons)
`define NGPD_ASSERT_NEVER(lbl, cond)
`endif
`endif

### hdl/ngpd_pkg.sv
package ngpd_pkg;

    // result kinds
    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_PIXEL  = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_MAGIC     = 3'd1;
    localparam logic [2:0] ERR_TYPE      = 3'd2;
    localparam logic [2:0] ERR_NUMBER    = 3'd3;
    localparam logic [2:0] ERR_EARLY_END = 3'd4;

    // register indexes
    localparam logic REG_WANT_COLOR = 1'b0;

    // characters
    localparam logic [7:0] CH_P         = 8'h50;
    localparam logic [7:0] CH_GRAY_ASC  = 8'h32;
    localparam logic [7:0] CH_GRAY_RAW  = 8'h35;
    localparam logic [7:0] CH_COLOR_ASC = 8'h33;
    localparam logic [7:0] CH_COLOR_RAW = 8'h36;
    localparam logic [7:0] CH_HASH      = 8'h23;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_NL        = 8'h0A;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    // one classified byte as it sits in the queue
    typedef struct packed {
        logic [7:0] byte_val;
        logic       eof;
        logic       is_digit;
        logic       is_space;
        logic       is_hash;
        logic       is_nl;
        logic [3:0] digit;
    } t_qword;

    // queue status toward the front and back
    typedef struct packed {
        logic empty;
        logic full;
    } t_qstat;

    // one result word
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [16:0] level_value;
        logic        ascii_mode;
        logic [7:0]  sample;
        logic        last_sample;
        logic [2:0]  error_code;
    } t_result;

endpackage

### hdl/ngpd_front.sv
module ngpd_front (
    input  logic             i_valid,
    input  logic [7:0]       i_byte_in,
    input  logic             i_end_of_file,
    input  ngpd_pkg::t_qstat i_qstat,
    output logic             o_stall,
    output logic             o_push,
    output ngpd_pkg::t_qword o_word
);
    import ngpd_pkg::*;

    logic [7:0] byte_off;

    // stall only on a full queue
    assign o_stall = i_qstat.full;
    assign o_push  = i_valid && !i_qstat.full;

    // classify the byte once, ahead of the queue
    assign byte_off = i_byte_in - CH_ZERO;

    always_comb begin
        o_word.byte_val = i_byte_in;
        o_word.eof      = i_end_of_file;
        o_word.is_digit = (i_byte_in >= CH_ZERO) && (i_byte_in <= CH_NINE);
        o_word.is_space = (i_byte_in == CH_SPACE) ||
                          ((i_byte_in >= CH_TAB) && (i_byte_in <= CH_CR));
        o_word.is_hash  = (i_byte_in == CH_HASH);
        o_word.is_nl    = (i_byte_in == CH_NL);
        o_word.digit    = byte_off[3:0];
    end

endmodule

### hdl/ngpd_queue.sv
module ngpd_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  ngpd_pkg::t_qword i_word,
    input  logic             i_pop,
    output ngpd_pkg::t_qword o_word,
    output ngpd_pkg::t_qstat o_qstat
);
    import ngpd_pkg::*;

    t_qword     r_mem [2];
    logic       r_wptr, n_wptr;
    logic       r_rptr, n_rptr;
    logic [1:0] r_count, n_count;

    assign o_word        = r_mem[r_rptr];
    assign o_qstat.empty = (r_count == 2'd0);
    assign o_qstat.full  = (r_count == 2'd2);

    // pointer and fill updates
    always_comb begin
        n_wptr  = i_push ? ~r_wptr : r_wptr;
        n_rptr  = i_pop  ? ~r_rptr : r_rptr;
        n_count = r_count + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_word;
        end
    end

endmodule

### hdl/ngpd_back.sv
module ngpd_back #(
    parameter int MAX_DIM_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_want_color,
    input  ngpd_pkg::t_qstat  i_qstat,
    input  ngpd_pkg::t_qword  i_word,
    output logic              o_pop,
    input  logic              i_stall,
    output logic              o_valid,
    output ngpd_pkg::t_result o_result
);
    import ngpd_pkg::*;

    localparam int D     = MAX_DIM_BITS;
    localparam int ACC_W = (MAX_DIM_BITS > 16) ? MAX_DIM_BITS : 16;
    localparam int AX_W  = ACC_W + 4;
    localparam logic [AX_W-1:0] DIM_LIMIT    = {{(AX_W-D){1'b0}}, {D{1'b1}}};
    localparam logic [AX_W-1:0] MAXVAL_LIMIT = {{(AX_W-16){1'b0}}, 16'hFFFF};

    typedef enum logic [7:0] {
        PH_MAGIC  = 8'b0000_0001,
        PH_TYPE   = 8'b0000_0010,
        PH_WIDTH  = 8'b0000_0100,
        PH_HEIGHT = 8'b0000_1000,
        PH_MAXVAL = 8'b0001_0000,
        PH_DATA   = 8'b0010_0000,
        PH_DONE   = 8'b0100_0000,
        PH_FAULT  = 8'b1000_0000
    } t_phase;

    t_phase       r_phase, n_phase;
    logic [ACC_W-1:0] r_acc, n_acc;
    logic         r_token, n_token;
    logic         r_comment, n_comment;
    logic [D-1:0] r_width, n_width;
    logic [D-1:0] r_height, n_height;
    logic         r_text, n_text;
    logic         r_color, n_color;
    logic [D-1:0] r_x, n_x;
    logic [D-1:0] r_y, n_y;
    logic [1:0]   r_band, n_band;
    logic [7:0]   r_sacc, n_sacc;
    logic         r_run, n_run;
    logic         r_out_valid, n_out_valid;
    t_result      r_out, n_out;

    logic             out_ready;
    logic             has_res;
    t_result          res;
    logic [AX_W-1:0]  acc_next;
    logic [AX_W-1:0]  limit;
    logic [7:0]       sacc_next;
    logic [ACC_W-1:0] width_ext;
    logic [ACC_W-1:0] height_ext;
    logic [D-1:0]     width_m1;
    logic [D-1:0]     height_m1;
    logic             last_band;
    logic             last_pos;
    logic             run_now;
    logic [7:0]       s_val;

    function automatic t_result make_error(input logic [2:0] code);
        t_result r;
        r            = '0;
        r.kind       = KIND_ERROR;
        r.error_code = code;
        return r;
    endfunction

    function automatic t_result make_sample(input logic [7:0] v, input logic last);
        t_result r;
        r             = '0;
        r.kind        = KIND_PIXEL;
        r.sample      = v;
        r.last_sample = last;
        return r;
    endfunction

    // take the next word only when the result slot is free or draining
    assign out_ready = !r_out_valid || !i_stall;
    assign o_pop     = !i_qstat.empty && out_ready;
    assign o_valid   = r_out_valid;
    assign o_result  = r_out;

    // datapath helpers
    assign acc_next   = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1) +
                        {{ACC_W{1'b0}}, i_word.digit};
    assign limit      = (r_phase == PH_MAXVAL) ? MAXVAL_LIMIT : DIM_LIMIT;
    assign sacc_next  = (r_sacc << 3) + (r_sacc << 1) + {4'b0, i_word.digit};
    assign width_ext  = ACC_W'(r_width);
    assign height_ext = ACC_W'(r_height);
    assign width_m1   = r_width - 1'b1;
    assign height_m1  = r_height - 1'b1;
    assign last_band  = r_color ? (r_band == 2'd2) : 1'b1;
    assign last_pos   = last_band && (r_x == width_m1) && (r_y == height_m1);

    // per-word state update
    always_comb begin
        n_phase   = r_phase;
        n_acc     = r_acc;
        n_token   = r_token;
        n_comment = r_comment;
        n_width   = r_width;
        n_height  = r_height;
        n_text    = r_text;
        n_color   = r_color;
        n_x       = r_x;
        n_y       = r_y;
        n_band    = r_band;
        n_sacc    = r_sacc;
        n_run     = r_run;
        res       = '0;
        has_res   = 1'b0;
        run_now   = 1'b0;
        s_val     = r_sacc;

        if (o_pop) begin
            unique case (r_phase) inside
                PH_MAGIC: begin
                    if (i_word.byte_val == CH_P) begin
                        n_phase = PH_TYPE;
                    end else begin
                        res     = make_error(ERR_MAGIC);
                        has_res = 1'b1;
                        n_phase = PH_FAULT;
                    end
                end
                PH_TYPE: begin
                    n_color = i_want_color;
                    if (i_word.byte_val == (i_want_color ? CH_COLOR_ASC : CH_GRAY_ASC)) begin
                        n_text  = 1'b1;
                        n_phase = PH_WIDTH;
                    end else if (i_word.byte_val ==
                                 (i_want_color ? CH_COLOR_RAW : CH_GRAY_RAW)) begin
                        n_text  = 1'b0;
                        n_phase = PH_WIDTH;
                    end else begin
                        res     = make_error(ERR_TYPE);
                        has_res = 1'b1;
                        n_phase = PH_FAULT;
                    end
                end
                PH_WIDTH, PH_HEIGHT, PH_MAXVAL: begin
                    if (r_comment) begin
                        if (i_word.is_nl) begin
                            n_comment = 1'b0;
                        end
                    end else if (i_word.is_digit) begin
                        n_acc   = acc_next[ACC_W-1:0];
                        n_token = 1'b1;
                        if (acc_next > limit) begin
                            res     = make_error(ERR_NUMBER);
                            has_res = 1'b1;
                            n_phase = PH_FAULT;
                        end
                    end else if (i_word.is_space || i_word.is_hash) begin
                        if (i_word.is_hash) begin
                            n_comment = 1'b1;
                        end
                        // a finished number moves the header along
                        if (r_token) begin
                            n_token = 1'b0;
                            n_acc   = '0;
                            if (r_phase == PH_WIDTH) begin
                                n_width = r_acc[D-1:0];
                                n_phase = PH_HEIGHT;
                            end else if (r_phase == PH_HEIGHT) begin
                                n_height = r_acc[D-1:0];
                                n_phase  = PH_MAXVAL;
                            end else begin
                                res.kind         = KIND_HEADER;
                                res.image_width  = width_ext[15:0];
                                res.image_height = height_ext[15:0];
                                res.level_value  = {1'b0, r_acc[15:0]} + {16'b0, r_color};
                                res.ascii_mode   = r_text;
                                has_res          = 1'b1;
                                n_x              = '0;
                                n_y              = '0;
                                n_band           = 2'd0;
                                n_phase = ((r_width == '0) || (r_height == '0)) ?
                                          PH_DONE : PH_DATA;
                            end
                        end
                    end else begin
                        res     = make_error(ERR_NUMBER);
                        has_res = 1'b1;
                        n_phase = PH_FAULT;
                    end
                end
                PH_DATA: begin
                    if (r_comment) begin
                        if (i_word.is_nl) begin
                            n_comment = 1'b0;
                        end
                    end else begin
                        // raw bytes go straight out, text digits build a run
                        if (!r_text) begin
                            run_now = 1'b1;
                            s_val   = i_word.byte_val;
                        end else if (i_word.is_digit) begin
                            run_now = 1'b1;
                            s_val   = sacc_next;
                        end else begin
                            run_now = r_run;
                            s_val   = r_sacc;
                        end
                        if (r_text && i_word.is_digit && !i_word.eof) begin
                            n_sacc = sacc_next;
                            n_run  = 1'b1;
                        end else if (run_now) begin
                            n_sacc  = '0;
                            n_run   = 1'b0;
                            res     = make_sample(s_val, last_pos);
                            has_res = 1'b1;
                            if (last_pos) begin
                                n_phase = PH_DONE;
                            end else if (!last_band) begin
                                n_band = r_band + 2'd1;
                            end else begin
                                n_band = 2'd0;
                                if (r_x == width_m1) begin
                                    n_x = '0;
                                    n_y = r_y + 1'b1;
                                end else begin
                                    n_x = r_x + 1'b1;
                                end
                            end
                        end
                    end
                end
                default: begin
                end
            endcase

            // end of file: flag an unfinished image, then start over
            if (i_word.eof) begin
                if ((n_phase != PH_DONE) && (n_phase != PH_FAULT)) begin
                    res     = make_error(ERR_EARLY_END);
                    has_res = 1'b1;
                end
                n_phase   = PH_MAGIC;
                n_acc     = '0;
                n_token   = 1'b0;
                n_comment = 1'b0;
                n_width   = '0;
                n_height  = '0;
                n_text    = 1'b0;
                n_color   = 1'b0;
                n_x       = '0;
                n_y       = '0;
                n_band    = 2'd0;
                n_sacc    = '0;
                n_run     = 1'b0;
            end
        end
    end

    // result register
    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (out_ready) begin
            n_out_valid = o_pop && has_res;
            n_out       = res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_MAGIC;
            r_acc       <= '0;
            r_token     <= 1'b0;
            r_comment   <= 1'b0;
            r_width     <= '0;
            r_height    <= '0;
            r_text      <= 1'b0;
            r_color     <= 1'b0;
            r_x         <= '0;
            r_y         <= '0;
            r_band      <= 2'd0;
            r_sacc      <= '0;
            r_run       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_acc       <= n_acc;
            r_token     <= n_token;
            r_comment   <= n_comment;
            r_width     <= n_width;
            r_height    <= n_height;
            r_text      <= n_text;
            r_color     <= n_color;
            r_x         <= n_x;
            r_y         <= n_y;
            r_band      <= n_band;
            r_sacc      <= n_sacc;
            r_run       <= n_run;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

endmodule

### hdl/netpbm_gray_pixmap_stream_decoder.sv
// Channel   Direction  Handshake            Payload
// bytes     in         i_valid / o_stall    i_byte_in, i_end_of_file
// results   out        o_valid / i_stall    o_kind .. o_error_code
// config    in         psel/penable/pwrite  paddr, pwdata, prdata, pready
//
// One byte per cycle unless o_stall; a result is registered as its byte is popped.
// The rate is set by the back end, which updates the parse state once per byte.
// A two-word queue sits between classifier and parser; o_stall rises when it is full.
// i_stall freezes a held result in the result register; the queue absorbs bytes until full.
// Reset is synchronous; no clearing pass follows.
`include "netpbm_gray_pixmap_stream_decoder_macros.svh"

module netpbm_gray_pixmap_stream_decoder #(
    parameter int MAX_DIM_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_byte_in,
    input  logic        i_end_of_file,
    // result output
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [15:0] o_image_width,
    output logic [15:0] o_image_height,
    output logic [16:0] o_level_value,
    output logic        o_ascii_mode,
    output logic [7:0]  o_sample,
    output logic        o_last_sample,
    output logic [2:0]  o_error_code,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ngpd_pkg::*;

    logic    r_want_color;
    logic    push;
    logic    pop;
    t_qword  front_word;
    t_qword  queue_word;
    t_qstat  qstat;
    t_result result;

    // configuration register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_WANT_COLOR) ? {31'b0, r_want_color} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_want_color <= 1'b0;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_WANT_COLOR)) begin
            r_want_color <= pwdata[0];
        end
    end

    ngpd_front u_front (
        .i_valid       (i_valid),
        .i_byte_in     (i_byte_in),
        .i_end_of_file (i_end_of_file),
        .i_qstat       (qstat),
        .o_stall       (o_stall),
        .o_push        (push),
        .o_word        (front_word)
    );

    ngpd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_word  (front_word),
        .i_pop   (pop),
        .o_word  (queue_word),
        .o_qstat (qstat)
    );

    ngpd_back #(
        .MAX_DIM_BITS (MAX_DIM_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_want_color (r_want_color),
        .i_qstat      (qstat),
        .i_word       (queue_word),
        .o_pop        (pop),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_result     (result)
    );

    // unpack the result word
    assign o_kind         = result.kind;
    assign o_image_width  = result.image_width;
    assign o_image_height = result.image_height;
    assign o_level_value  = result.level_value;
    assign o_ascii_mode   = result.ascii_mode;
    assign o_sample       = result.sample;
    assign o_last_sample  = result.last_sample;
    assign o_error_code   = result.error_code;

    // checks
    `NGPD_ASSERT_NEVER(a_queue_status, qstat.empty && qstat.full)
    `NGPD_ASSERT_IMP(a_error_coded, o_valid && (o_kind == KIND_ERROR), o_error_code != ERR_NONE)
    `NGPD_ASSERT_IMP(a_last_is_pixel, o_valid && o_last_sample, o_kind == KIND_PIXEL)
    `NGPD_ASSERT_IMP(a_header_clean, o_valid && (o_kind == KIND_HEADER), (o_error_code == ERR_NONE) && (o_sample == 8'd0))

endmodule
